FILE: rtl/sff_pkg.sv
// ----------------------------------------------------------------------------
// sff_pkg
// Types and constants shared by the sensor fault fallback block.
// ----------------------------------------------------------------------------
`default_nettype none

package sff_pkg;

  localparam int CHANNELS  = 4;
  localparam int CH_W      = 2;
  localparam int SAMPLE_W  = 12;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [CNT_W-1:0]    CNT_MAX         = '1;
  localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST   = SAMPLE_W'(500);
  localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RST  = SAMPLE_W'(3800);
  localparam logic [CNT_W-1:0]    FAULT_THRSH_RST = CNT_W'(3);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OPEN  = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT   = 2'd0,
    REG_HIGH_LIMIT  = 2'd1,
    REG_FAULT_THRSH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_limit;
    logic [SAMPLE_W-1:0] high_limit;
    logic [CNT_W-1:0]    fault_thrsh;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] raw_sample;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    status_t             status;
    logic                all_faulted;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/sff_intf.sv
// ----------------------------------------------------------------------------
// sff_intf
// Valid/ready channel interfaces: sample input, result output, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface sff_in_if import sff_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, channel, raw_sample, input ready);
  modport sink   (input valid, channel, raw_sample, output ready);
endinterface

interface sff_out_if import sff_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;
  logic [1:0]          status;
  logic                all_faulted;

  modport source (output valid, sample_out, status, all_faulted, input ready);
  modport sink   (input valid, sample_out, status, all_faulted, output ready);
endinterface

interface sff_cfg_if import sff_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sff_cfg_regs.sv
// ----------------------------------------------------------------------------
// sff_cfg_regs
// Limit and threshold registers, written one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sff_cfg_regs import sff_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  sff_cfg_if.sink           cfg_wr,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_LOW_LIMIT:   cfg_nxt.low_limit   = cfg_wr.data[SAMPLE_W-1:0];
        REG_HIGH_LIMIT:  cfg_nxt.high_limit  = cfg_wr.data[SAMPLE_W-1:0];
        REG_FAULT_THRSH: cfg_nxt.fault_thrsh = cfg_wr.data[CNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit   <= LOW_LIMIT_RST;
      cfg_r.high_limit  <= HIGH_LIMIT_RST;
      cfg_r.fault_thrsh <= FAULT_THRSH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sff_core.sv
// ----------------------------------------------------------------------------
// sff_core
// Per-channel fault counters and last-good store; evaluates one item per cycle, updating state only when fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sff_core import sff_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output result_t    res
);

  logic [CNT_W-1:0]    cnt_r    [CHANNELS];
  logic [CNT_W-1:0]    cnt_nxt  [CHANNELS];
  logic [SAMPLE_W-1:0] good_r   [CHANNELS];
  logic [SAMPLE_W-1:0] good_nxt [CHANNELS];

  logic                ch_ok;
  logic                is_open;
  logic                is_short;
  logic                fault;
  logic [CNT_W-1:0]    cnt_cur;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SAMPLE_W-1:0] good_cur;
  logic                fallback;
  logic                all_hit;

  assign ch_ok    = 32'(item.channel) < CHANNELS;
  assign is_open  = item.raw_sample < cfg.low_limit;
  assign is_short = !is_open && (item.raw_sample > cfg.high_limit);
  assign fault    = is_open || is_short;
  assign cnt_cur  = cnt_r[item.channel];
  assign good_cur = good_r[item.channel];
  assign cnt_inc  = (cnt_cur != CNT_MAX) ? cnt_cur + CNT_W'(1) : cnt_cur;
  assign fallback = ch_ok && fault && (cnt_inc >= cfg.fault_thrsh);

  always_comb begin
    all_hit = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      good_nxt[i] = good_r[i];
      if (fire && ch_ok && item.channel == CH_W'(i)) begin
        if (fault) begin
          cnt_nxt[i] = cnt_inc;
        end else begin
          cnt_nxt[i]  = '0;
          good_nxt[i] = item.raw_sample;
        end
      end
      if (cnt_nxt[i] < cfg.fault_thrsh) begin
        all_hit = 1'b0;
      end
    end
  end

  always_comb begin
    res.all_faulted = all_hit;
    if (!ch_ok) begin
      res.sample_out = '0;
      res.status     = ST_OPEN;
    end else if (fallback) begin
      res.sample_out = good_cur;
      res.status     = is_open ? ST_OPEN : ST_SHORT;
    end else begin
      res.sample_out = item.raw_sample;
      res.status     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i]  <= '0;
        good_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i]  <= cnt_nxt[i];
        good_r[i] <= good_nxt[i];
      end
    end
  end

`ifndef ASSERT_OFF
  a_clear_on_good: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ch_ok && !fault |=> cnt_r[$past(item.channel)] == '0)
    else $error("fault counter not cleared by in-range sample");

  a_count_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ch_ok && fault |=> cnt_r[$past(item.channel)] == $past(cnt_inc))
    else $error("fault counter did not advance on faulty sample");

  a_zero_thrsh: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cfg.fault_thrsh == '0 |-> res.all_faulted)
    else $error("zero threshold must report all channels faulted");

  a_good_latch: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ch_ok && !fault |=> good_r[$past(item.channel)] == $past(item.raw_sample))
    else $error("last good sample not stored");
`endif

endmodule

`default_nettype wire

FILE: rtl/sensor_fault_fallback.sv
// ----------------------------------------------------------------------------
// sensor_fault_fallback
// Converter sample plausibility check with last-good hold, top level.
// ----------------------------------------------------------------------------
// Each beat on in_chan carries a channel and a raw 12-bit sample; each yields
// exactly one beat on out_chan, in order. The block accepts one sample per
// clock while out_chan is not stalled: a beat is held in an input register,
// evaluated against the limit registers and that channel's fault counter, and
// lands in an output register when it advances, from which its result beat
// leaves. The counter and last-good update is a read-modify-write per
// channel, which sets the one-beat-per-clock rate. Limits and threshold are
// written on cfg_wr (index 0 low limit, 1 high limit, 2 fault threshold); the
// user must write them only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_fault_fallback import sff_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sff_in_if.sink    in_chan,
  sff_out_if.source out_chan,
  sff_cfg_if.sink   cfg_wr
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  logic    in_vld_nxt;
  result_t core_res;
  result_t res_r;
  logic    out_vld_r;
  logic    out_vld_nxt;
  logic    advance;
  logic    in_take;

  sff_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  sff_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  assign advance       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.channel    <= in_chan.channel;
      item_r.raw_sample <= in_chan.raw_sample;
    end
    if (advance) begin
      res_r <= core_res;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.sample_out  = res_r.sample_out;
  assign out_chan.status      = res_r.status;
  assign out_chan.all_faulted = res_r.all_faulted;

`ifndef ASSERT_OFF
  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(item_r))
    else $error("input stage lost a stalled beat");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_chan.ready |-> !advance)
    else $error("result register overwritten while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_chan.status <= ST_SHORT)
    else $error("undefined status code on output");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sensor_fault_fallback. A directed table opens the
// run with reset limits. Random bursts per channel follow under several limit
// and threshold settings, among them threshold zero, crossed limits and a
// saturating fault run. Every result beat is compared against its table
// entry or a cycle-free model of the counters and last-good store kept here.
// ----------------------------------------------------------------------------

module tb;
  import sff_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int DIR_ROWS     = 20;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 200;
  localparam int CALM_FROM    = 1000;
  localparam int CALM_TO      = 1300;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] raw;
    logic                typed;
    result_t             want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sff_in_if  in_if ();
  sff_out_if out_if ();
  sff_cfg_if cfg_if ();

  sensor_fault_fallback i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_wr   (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  cfg_t                lim_cfg;
  logic [SAMPLE_W-1:0] held_sample [CHANNELS];
  logic [CNT_W-1:0]    fault_run [CHANNELS];
  result_t             pending_results [$];

  int errors    = 0;
  int beats_in  = 0;
  int beats_out = 0;
  int cycles    = 0;

  // after reset: fallback with nothing stored, limit edges, all channels faulted
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{2'd0, 12'd0,    1'b1, '{12'd0,    ST_OK,    1'b0}},
    '{2'd0, 12'd4095, 1'b1, '{12'd4095, ST_OK,    1'b0}},
    '{2'd0, 12'd499,  1'b1, '{12'd0,    ST_OPEN,  1'b0}},
    '{2'd0, 12'd500,  1'b1, '{12'd500,  ST_OK,    1'b0}},
    '{2'd0, 12'd3800, 1'b1, '{12'd3800, ST_OK,    1'b0}},
    '{2'd0, 12'd3801, 1'b0, '0},
    '{2'd0, 12'd3801, 1'b0, '0},
    '{2'd0, 12'd4095, 1'b1, '{12'd3800, ST_SHORT, 1'b0}},
    '{2'd1, 12'd0,    1'b0, '0},
    '{2'd1, 12'd1,    1'b0, '0},
    '{2'd1, 12'd2,    1'b0, '0},
    '{2'd2, 12'd4095, 1'b0, '0},
    '{2'd2, 12'd4094, 1'b0, '0},
    '{2'd2, 12'd4000, 1'b0, '0},
    '{2'd3, 12'd0,    1'b0, '0},
    '{2'd3, 12'd4095, 1'b0, '0},
    '{2'd3, 12'd4095, 1'b0, '0},
    '{2'd3, 12'hAAA,  1'b0, '0},
    '{2'd1, 12'h555,  1'b0, '0},
    '{2'd2, 12'h7FF,  1'b0, '0}
  };

  function automatic result_t predict_sample(logic [CH_W-1:0] ch,
                                             logic [SAMPLE_W-1:0] raw);
    result_t r;
    bit      is_open;
    bit      is_short;
    int      c;
    c = int'(ch);
    r.sample_out = raw;
    r.status     = ST_OK;
    if (c >= CHANNELS) begin
      r.sample_out = '0;
      r.status     = ST_OPEN;
    end else begin
      is_open  = raw < lim_cfg.low_limit;
      is_short = !is_open && raw > lim_cfg.high_limit;
      if (is_open || is_short) begin
        if (fault_run[c] != CNT_MAX) fault_run[c] = fault_run[c] + 1'b1;
        if (fault_run[c] >= lim_cfg.fault_thrsh) begin
          r.sample_out = held_sample[c];
          r.status     = is_open ? ST_OPEN : ST_SHORT;
        end
      end else begin
        fault_run[c]   = '0;
        held_sample[c] = raw;
      end
    end
    r.all_faulted = 1'b1;
    for (int i = 0; i < CHANNELS; i++)
      if (fault_run[i] < lim_cfg.fault_thrsh) r.all_faulted = 1'b0;
    return r;
  endfunction

  function automatic void flag(string what, int want_v, int got_v);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %0d, got %0d (beat %0d)", what, want_v, got_v,
               beats_out);
  endfunction

  task automatic check_beat();
    result_t want;
    if (pending_results.size() == 0) begin
      flag("unexpected beat, sample_out", -1, int'(out_if.sample_out));
      return;
    end
    want = pending_results.pop_front();
    if (out_if.sample_out !== want.sample_out)
      flag("sample_out", int'(want.sample_out), int'(out_if.sample_out));
    if (out_if.status !== want.status)
      flag("status", int'(want.status), int'(out_if.status));
    if (out_if.all_faulted !== want.all_faulted)
      flag("all_faulted", int'(want.all_faulted), int'(out_if.all_faulted));
  endtask

  // leaves valid high on return; the caller decides the next beat
  task automatic send_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] raw,
                             logic typed, result_t want);
    result_t model_res;
    while (!(beats_in >= CALM_FROM && beats_in < CALM_TO) &&
           $urandom_range(0, 99) < 7) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.channel    <= ch;
    in_if.raw_sample <= raw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    model_res = predict_sample(ch, raw);
    pending_results.push_back(typed ? want : model_res);
    beats_in++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_LOW_LIMIT:   lim_cfg.low_limit   = val;
      REG_HIGH_LIMIT:  lim_cfg.high_limit  = val;
      REG_FAULT_THRSH: lim_cfg.fault_thrsh = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(int lo, int hi, int thr);
    wait_idle();
    write_reg(REG_LOW_LIMIT,   CFG_DAT_W'(lo));
    write_reg(REG_HIGH_LIMIT,  CFG_DAT_W'(hi));
    write_reg(REG_FAULT_THRSH, CFG_DAT_W'(thr));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_raw(bit faults_only);
    int          lo;
    int          hi;
    int unsigned pick;
    lo   = int'(lim_cfg.low_limit);
    hi   = int'(lim_cfg.high_limit);
    pick = faults_only ? $urandom_range(4, 5) : $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: return SAMPLE_W'($urandom_range(lo, hi));
      4:          return (lo == 0) ? '1 : SAMPLE_W'($urandom_range(0, lo - 1));
      5:          return (hi == 4095) ? '0 : SAMPLE_W'($urandom_range(hi + 1, 4095));
      6: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return '1;
          2:       return SAMPLE_W'(lo);
          3:       return SAMPLE_W'(hi);
          4:       return SAMPLE_W'(lo - 1);
          default: return SAMPLE_W'(hi + 1);
        endcase
      end
      default:    return SAMPLE_W'($urandom);
    endcase
  endfunction

  // bursts on one channel so fault runs cross the threshold
  task automatic run_bursts(int n, bit faults_only);
    int              sent;
    int              burst;
    logic [CH_W-1:0] ch;
    sent = 0;
    while (sent < n) begin
      ch    = (faults_only && $urandom_range(0, 4) != 0) ? '0
              : CH_W'($urandom_range(0, CHANNELS - 1));
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_sample(ch, pick_raw(faults_only), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // result side: random stalls, one long hold-off, a calm stretch
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        check_beat();
        beats_out++;
      end
      if (!hold_done && beats_out >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= (beats_out >= CALM_FROM && beats_out < CALM_TO) ||
                        ($urandom_range(0, 99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.channel    <= '0;
    in_if.raw_sample <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_LOW_LIMIT;
    cfg_if.data      <= '0;
    lim_cfg.low_limit   = LOW_LIMIT_RST;
    lim_cfg.high_limit  = HIGH_LIMIT_RST;
    lim_cfg.fault_thrsh = FAULT_THRSH_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      held_sample[i] = '0;
      fault_run[i]   = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      send_sample(dir_rows[r].ch, dir_rows[r].raw, dir_rows[r].typed, dir_rows[r].want);

    set_limits(500, 3800, 3);
    run_bursts(400, 0);
    set_limits(0, 4095, 255);      // nothing can fault
    run_bursts(100, 0);
    set_limits(4095, 0, 0);        // threshold zero, crossed limits
    run_bursts(150, 0);
    set_limits(2000, 1000, 1);
    run_bursts(150, 0);
    set_limits(4000, 4095, 255);   // long fault runs, counters saturate
    run_bursts(400, 1);
    repeat (3) begin
      set_limits($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 8));
      run_bursts(200, 0);
    end
    wait_idle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
